// ===== rtl/core/msbd_pkg.sv =====
`default_nettype none

package msbd_pkg;

	// Generator matrix: eight rows, one code word each
	localparam int ROW_COUNT = 8;
	localparam int CFG_IDX_W = 3;
	localparam int WORD_W    = 16;

	// Distance output width and its saturation value
	localparam int DIST_W = 27;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// BPSK level for +1.0 in sample units
	localparam int ONE_LEVEL = 512;

	// Tag that travels with each position through the distance pipeline
	typedef struct packed {
		logic valid;
		logic first_pos;
		logic last_pos;
		logic first_cand;
		logic last_cand;
	} tag_t;

endpackage

`default_nettype wire

// ===== rtl/core/ml_soft_block_decoder.sv =====
`default_nettype none
// Maximum likelihood soft decision block decoder.
// Samples arrive on soft_sample, one request per cycle at most, taken at a
// clock edge with start high and busy low. After CODE_LENGTH samples the
// block raises busy and tries every code word: messages 1 .. 2^MESSAGE_BITS-1
// and then 0, each word the XOR of the generator rows its message selects.
// One squaring multiplier and one accumulator are shared by all candidates;
// each candidate is scored over all CODE_LENGTH positions, one per cycle.
// When the search is over, result_valid pulses for exactly one cycle with
// decoded_codeword and best_distance, and busy drops in the same cycle.
// No request is taken while busy is high; the first request of the next
// block may be taken in the result cycle.
// The receiver cannot stall: the result is shown once and not repeated.
// Generator rows are written through cfg_we / cfg_index / cfg_wdata; the
// user must write them only while the block is idle, which the block itself
// does not enforce. Reset clears the rows, the sample count and all control
// state; a partly collected block is dropped.
module ml_soft_block_decoder
	import msbd_pkg::*;
#(
	parameter int CODE_LENGTH  = 16,
	parameter int MESSAGE_BITS = 8,
	parameter int SAMPLE_BITS  = 12
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [SAMPLE_BITS-1:0] soft_sample,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [WORD_W-1:0]      cfg_wdata,
	output logic                        result_valid,
	output logic [WORD_W-1:0]           decoded_codeword,
	output logic [DIST_W-1:0]           best_distance
);

	localparam int POS_W  = $clog2(CODE_LENGTH);
	localparam int CAND_W = MESSAGE_BITS + 1;
	localparam int MAG_W  = (SAMPLE_BITS > 10) ? SAMPLE_BITS : 10;
	localparam int DW     = MAG_W + 2;
	localparam int SQW    = 2 * DW;
	localparam int AW     = SQW + POS_W;
	localparam int CW     = (AW > DIST_W) ? AW : DIST_W;
	localparam int XW     = (CODE_LENGTH > WORD_W) ? CODE_LENGTH : WORD_W;

	localparam logic [POS_W-1:0]  POS_LAST = POS_W'(CODE_LENGTH - 1);
	localparam logic [CAND_W-1:0] CAND_ONE = CAND_W'(1);
	localparam logic [CAND_W-1:0] CAND_END = CAND_W'(2 ** MESSAGE_BITS);
	localparam logic signed [DW-1:0] LVL   = DW'(ONE_LEVEL);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]             state_q;
	logic [WORD_W-1:0]      gen_row_q [ROW_COUNT];
	logic [SAMPLE_BITS-1:0] sample_mem [CODE_LENGTH];
	logic [POS_W-1:0]       cnt_q;
	logic [POS_W-1:0]       pos_q;
	logic [CAND_W-1:0]      cand_q;
	logic [WORD_W-1:0]      word_q;

	logic [SAMPLE_BITS-1:0] samp_s1;
	logic                   bit_s1;
	logic [WORD_W-1:0]      word_s1;
	tag_t                   tag_s1;
	logic [SQW-1:0]         sq_s2;
	logic [WORD_W-1:0]      word_s2;
	tag_t                   tag_s2;

	logic [AW-1:0]          acc_q;
	logic [AW-1:0]          best_dist_q;
	logic [WORD_W-1:0]      best_word_q;
	logic [WORD_W-1:0]      res_word_q;
	logic [DIST_W-1:0]      res_dist_q;
	logic                   done_q;

	logic                   accept;
	logic                   issue;
	logic                   cand_wrap;
	logic [MESSAGE_BITS-1:0] msg_next;
	logic [WORD_W-1:0]      word_next;
	logic [XW-1:0]          word_x;
	logic signed [DW-1:0]   samp_ext;
	logic signed [DW-1:0]   diff;
	logic signed [SQW-1:0]  diff_w;
	logic [SQW-1:0]         sq;
	tag_t                   tag_now;
	logic [AW-1:0]          acc_sum;
	logic                   take_new;
	logic                   finish;
	logic [AW-1:0]          fin_dist;
	logic [WORD_W-1:0]      fin_word;
	logic [DIST_W-1:0]      fin_sat;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign issue  = (state_q == ST_RUN);

	// Next candidate word: XOR of rows selected by the next message
	assign msg_next = MESSAGE_BITS'(cand_q + CAND_ONE);
	always_comb begin
		word_next = '0;
		for (int b = 0; b < MESSAGE_BITS; b++) begin
			if (msg_next[b]) begin
				word_next = word_next ^ gen_row_q[b];
			end
		end
	end

	// Stage 0: pick the code bit; the sample is read in the datapath block
	assign word_x    = XW'(word_q);
	assign cand_wrap = (cand_q == CAND_END);

	always_comb begin
		tag_now.valid      = issue;
		tag_now.first_pos  = (pos_q == '0);
		tag_now.last_pos   = (pos_q == POS_LAST);
		tag_now.first_cand = (cand_q == CAND_ONE);
		tag_now.last_cand  = cand_wrap;
	end

	// Stage 1: sample minus the sent level, then the squaring multiplier
	assign samp_ext = DW'($signed(samp_s1));
	assign diff     = bit_s1 ? (samp_ext + LVL) : (samp_ext - LVL);
	assign diff_w   = SQW'(diff);
	assign sq       = $unsigned(diff_w * diff_w);

	// Stage 2: accumulate and compare against the best so far
	assign acc_sum  = (tag_s2.first_pos ? '0 : acc_q) + AW'(sq_s2);
	assign take_new = tag_s2.first_cand || (acc_sum < best_dist_q);
	assign finish   = tag_s2.valid && tag_s2.last_pos && tag_s2.last_cand;
	assign fin_dist = take_new ? acc_sum : best_dist_q;
	assign fin_word = take_new ? word_s2 : best_word_q;
	assign fin_sat  = (CW'(fin_dist) > CW'(DIST_MAX)) ? DIST_MAX : DIST_W'(fin_dist);

	// Control: sequencer, counters, generator rows, pipeline tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			cand_q  <= '0;
			tag_s1  <= '0;
			tag_s2  <= '0;
			done_q  <= 1'b0;
			for (int r = 0; r < ROW_COUNT; r++) begin
				gen_row_q[r] <= '0;
			end
		end else begin
			if (cfg_we) begin
				gen_row_q[cfg_index] <= cfg_wdata;
			end
			tag_s1 <= tag_now;
			tag_s2 <= tag_s1;
			done_q <= finish;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cnt_q == POS_LAST) begin
							cnt_q   <= '0;
							pos_q   <= '0;
							cand_q  <= CAND_ONE;
							state_q <= ST_RUN;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (pos_q == POS_LAST) begin
						pos_q <= '0;
						if (cand_wrap) begin
							cand_q  <= '0;
							state_q <= ST_DRAIN;
						end else begin
							cand_q <= cand_q + 1'b1;
						end
					end else begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: sample store, candidate word, pipeline payload, best tracking
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_mem[cnt_q] <= soft_sample;
		end
		if ((accept && cnt_q == POS_LAST) || (issue && pos_q == POS_LAST && !cand_wrap)) begin
			word_q <= word_next;
		end
		samp_s1 <= sample_mem[pos_q];
		bit_s1  <= word_x[pos_q];
		word_s1 <= word_q;
		sq_s2   <= sq;
		word_s2 <= word_s1;
		if (tag_s2.valid) begin
			acc_q <= acc_sum;
			if (tag_s2.last_pos && take_new) begin
				best_dist_q <= acc_sum;
				best_word_q <= word_s2;
			end
		end
	end

	// Result registers, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_word_q <= '0;
			res_dist_q <= '0;
		end else if (finish) begin
			res_word_q <= fin_word;
			res_dist_q <= fin_sat;
		end
	end

	assign result_valid     = done_q;
	assign decoded_codeword = res_word_q;
	assign best_distance    = res_dist_q;

endmodule

`default_nettype wire

// ===== rtl/core/msbd_chk.sv =====
`default_nettype none

module msbd_chk
	import msbd_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic              result_valid,
	input wire logic [DIST_W-1:0] best_distance
);

	// A result is a single-cycle strobe
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe held longer than one cycle");

	// The search only begins after a request was taken
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

	// The end of a search always delivers its result
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> result_valid)
		else $error("search ended without a result");

	// Results are shown only when the block is idle again
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!busy && $past(busy)))
		else $error("result shown while still searching");

	// Distance stays stable while the block is idle and no new result is shown
	a_dist_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!result_valid && !busy && $past(!busy)) |-> $stable(best_distance))
		else $error("distance changed outside a search");

endmodule

bind ml_soft_block_decoder msbd_chk u_msbd_chk (.*);

`default_nettype wire
